FILE: rtl/sbca_pkg.sv
// Shared constants, types and helper functions of the sprite blitter.
package sbca_pkg;

    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_SCALE   = 4;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int PHYS_STRIDE = MAX_COLS * MAX_SCALE;
    localparam int PHYS_W      = $clog2(PHYS_STRIDE);
    localparam int FRAME_AW    = ROW_W + PHYS_W;
    localparam int OWNER_AW    = ROW_W + COL_W;
    localparam int FRAME_WORDS = MAX_ROWS * PHYS_STRIDE;
    localparam int OWNER_WORDS = MAX_ROWS * MAX_COLS;
    localparam int ALPHA_LSB   = 24;

    localparam logic [10:0] OWNER_NONE = 11'h7FF;

    // Item kinds carried in s_tuser
    localparam logic [1:0] ACT_HDR  = 2'd0;
    localparam logic [1:0] ACT_PIX  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRAME_COLS = 3'd0;
    localparam logic [2:0] REG_FRAME_ROWS = 3'd1;
    localparam logic [2:0] REG_SCALE      = 3'd2;
    localparam logic [2:0] REG_PAN_X      = 3'd3;
    localparam logic [2:0] REG_PAN_Y      = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic hdr;       // load sprite header
        logic latch;     // capture pixel or read payload
        logic px_step;   // evaluate pixel, advance counters, latch base
        logic own_wr;    // write owner map, load opaque write data
        logic fr_rd;     // read frame word at pixel base
        logic bl_mul;    // blend products
        logic bl_fin;    // blend finish into write data
        logic fr_wr;     // write one copy
        logic rd_issue;  // read both stores at read address
        logic out_load;  // load result register
    } sbca_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic active;
        logic clipped;
        logic blend;
        logic alpha_nz;
        logic last_copy;
        logic out_busy;
    } sbca_stat_t;

    // Scale 0 acts as 1, above MAX_SCALE acts as MAX_SCALE
    function automatic logic [2:0] eff_scale(input logic [2:0] s);
        logic [2:0] r;
        if (s == 3'd0)
            r = 3'd1;
        else if (32'(s) > MAX_SCALE)
            r = 3'(MAX_SCALE);
        else
            r = s;
        return r;
    endfunction

    // 16-bit value divided by an effective scale of 1..4
    function automatic logic [15:0] div_scale(input logic [15:0] x, input logic [2:0] sc);
        logic [32:0] prod;
        logic [15:0] q;
        prod = 33'(x) * 33'h0AAAB;
        case (sc)
            3'd2: q = x >> 1;
            3'd3: q = prod[32:17];
            3'd4: q = x >> 2;
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

FILE: rtl/sbca_ctrl.sv
// Controller state machine of the sprite blitter.
module sbca_ctrl
    import sbca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    input  sbca_stat_t stat,
    output logic       in_ready,
    output sbca_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PX,
        ST_BMUL,
        ST_BFIN,
        ST_WR,
        ST_RD,
        ST_RLD
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_action)
                        ACT_HDR:  cmd.hdr = 1'b1;
                        ACT_PIX:
                        begin
                            cmd.latch  = 1'b1;
                            state_next = ST_PX;
                        end
                        ACT_READ:
                        begin
                            cmd.latch  = 1'b1;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PX:
            begin
                state_next = ST_IDLE;
                if (stat.active)
                begin
                    cmd.px_step = 1'b1;
                    if (!stat.clipped)
                    begin
                        if (stat.blend)
                        begin
                            cmd.fr_rd  = 1'b1;
                            state_next = ST_BMUL;
                        end
                        else
                        begin
                            cmd.own_wr = 1'b1;
                            if (stat.alpha_nz)
                                state_next = ST_WR;
                        end
                    end
                end
            end
            ST_BMUL:
            begin
                cmd.bl_mul = 1'b1;
                state_next = ST_BFIN;
            end
            ST_BFIN:
            begin
                cmd.bl_fin = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.fr_wr = 1'b1;
                if (stat.last_copy)
                    state_next = ST_IDLE;
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RLD;
            end
            ST_RLD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/sbca_dp.sv
// Datapath of the sprite blitter: registers, counters, stores, blend and result.
module sbca_dp
    import sbca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sbca_cmd_t    cmd,
    output sbca_stat_t   stat,
    input  logic [111:0] s_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata
);

    // Input field unpacking
    logic [15:0] in_sx, in_sy;
    logic [8:0]  in_w, in_h;
    logic        in_blend;
    logic [10:0] in_owner;
    logic [31:0] in_argb;
    logic [9:0]  in_col;
    logic [7:0]  in_row;

    assign in_sx    = s_tdata[15:0];
    assign in_sy    = s_tdata[31:16];
    assign in_w     = s_tdata[40:32];
    assign in_h     = s_tdata[49:41];
    assign in_blend = s_tdata[50];
    assign in_owner = s_tdata[61:51];
    assign in_argb  = s_tdata[93:62];
    assign in_col   = s_tdata[103:94];
    assign in_row   = s_tdata[111:104];

    // Configuration registers
    logic [8:0]  frame_cols_reg, frame_rows_reg;
    logic [2:0]  scale_reg;
    logic [15:0] pan_x_reg, pan_y_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg <= 9'd256;
            frame_rows_reg <= 9'd256;
            scale_reg      <= 3'd1;
            pan_x_reg      <= '0;
            pan_y_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_FRAME_COLS: frame_cols_reg <= pwdata[8:0];
                REG_FRAME_ROWS: frame_rows_reg <= pwdata[8:0];
                REG_SCALE:      scale_reg      <= pwdata[2:0];
                REG_PAN_X:      pan_x_reg      <= pwdata[15:0];
                REG_PAN_Y:      pan_y_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FRAME_COLS: prdata = {23'b0, frame_cols_reg};
            REG_FRAME_ROWS: prdata = {23'b0, frame_rows_reg};
            REG_SCALE:      prdata = {29'b0, scale_reg};
            REG_PAN_X:      prdata = {16'b0, pan_x_reg};
            REG_PAN_Y:      prdata = {16'b0, pan_y_reg};
            default:        prdata = '0;
        endcase
    end

    // Sprite state
    logic signed [17:0] origin_col_reg, origin_row_reg, origin_col_next, origin_row_next;
    logic [8:0]  span_w_reg, span_h_reg, col_cnt_reg, row_cnt_reg;
    logic        mode_reg;
    logic [10:0] owner_reg;
    logic [2:0]  sc_now;

    assign sc_now = eff_scale(scale_reg);
    assign origin_col_next = 18'($signed(in_sx)) - $signed({2'b0, div_scale(pan_x_reg, sc_now)});
    assign origin_row_next = 18'($signed(in_sy)) - $signed({2'b0, div_scale(pan_y_reg, sc_now)});

    // Pixel position and clipping
    logic signed [18:0] pc, pr;
    logic [8:0]  fc, fr;
    logic        active, clipped;
    logic [PHYS_W-1:0]   phys_col;
    logic [FRAME_AW-1:0] base_comb;
    logic [OWNER_AW-1:0] own_waddr;
    logic [9:0]  col_inc;

    assign pc = $signed({origin_col_reg[17], origin_col_reg}) + $signed({10'b0, col_cnt_reg});
    assign pr = $signed({origin_row_reg[17], origin_row_reg}) + $signed({10'b0, row_cnt_reg});
    assign fc = (32'(frame_cols_reg) > MAX_COLS) ? 9'(MAX_COLS) : frame_cols_reg;
    assign fr = (32'(frame_rows_reg) > MAX_ROWS) ? 9'(MAX_ROWS) : frame_rows_reg;
    assign active  = (span_w_reg != 9'd0) && (row_cnt_reg < span_h_reg);
    assign clipped = pc[18] || pr[18] || (pc[17:0] >= {9'b0, fc}) || (pr[17:0] >= {9'b0, fr});
    assign phys_col  = PHYS_W'({2'b0, pc[COL_W-1:0]} * {7'b0, sc_now});
    assign base_comb = {pr[ROW_W-1:0], phys_col};
    assign own_waddr = {pr[ROW_W-1:0], pc[COL_W-1:0]};
    assign col_inc   = {1'b0, col_cnt_reg} + 10'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_col_reg <= '0;
            origin_row_reg <= '0;
            span_w_reg     <= '0;
            span_h_reg     <= '0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            mode_reg       <= 1'b0;
            owner_reg      <= '0;
        end
        else if (cmd.hdr)
        begin
            origin_col_reg <= origin_col_next;
            origin_row_reg <= origin_row_next;
            span_w_reg     <= in_w;
            span_h_reg     <= in_h;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            mode_reg       <= in_blend;
            owner_reg      <= in_owner;
        end
        else if (cmd.px_step)
        begin
            if (col_inc >= {1'b0, span_w_reg})
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_cnt_reg + 9'd1;
            end
            else
                col_cnt_reg <= col_inc[8:0];
        end
    end

    // Copy counter over the replicated columns
    logic [2:0] copy_reg, sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_reg <= '0;
            sc_reg   <= 3'd1;
        end
        else if (cmd.px_step)
        begin
            copy_reg <= '0;
            sc_reg   <= sc_now;
        end
        else if (cmd.fr_wr)
            copy_reg <= copy_reg + 3'd1;
    end

    // Payload captures and blend
    logic [31:0] argb_reg, wdata_reg, fr_q;
    logic [9:0]  rcol_reg;
    logic [7:0]  rrow_reg;
    logic [FRAME_AW-1:0] base_reg;
    logic [31:0] prod_reg [3];
    logic [10:0] own_q;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            argb_reg <= in_argb;
            rcol_reg <= in_col;
            rrow_reg <= in_row;
        end
        if (cmd.px_step)
            base_reg <= base_comb;
        if (cmd.own_wr)
            wdata_reg <= argb_reg;
        if (cmd.bl_mul)
        begin
            for (int ch = 0; ch < 3; ch++)
                prod_reg[ch] <= {24'b0, argb_reg[31:ALPHA_LSB]}
                              * (32'(argb_reg[8*ch +: 8]) - 32'(fr_q[8*ch +: 8]));
        end
        if (cmd.bl_fin)
        begin
            for (int ch = 0; ch < 3; ch++)
                wdata_reg[8*ch +: 8] <= 8'(((prod_reg[ch] + 32'd1 + (prod_reg[ch] >> 8)) >> 8))
                                      + fr_q[8*ch +: 8];
            wdata_reg[31:24] <= fr_q[31:24];
        end
    end

    // Read address and range check
    logic [15:0] ocol;
    logic        oob, oob_reg;

    assign ocol = div_scale({6'b0, rcol_reg}, sc_now);
    assign oob  = (32'(rrow_reg) >= MAX_ROWS) || (32'(rcol_reg) >= PHYS_STRIDE)
               || (32'(ocol) >= MAX_COLS);

    // Frame store: one write port, one registered read port
    logic [31:0] frame_mem [FRAME_WORDS];
    logic [FRAME_AW-1:0] fr_raddr;

    assign fr_raddr = cmd.rd_issue ? FRAME_AW'({rrow_reg, rcol_reg}) : base_comb;

    always_ff @(posedge clk)
    begin
        if (cmd.fr_wr)
            frame_mem[base_reg + FRAME_AW'(copy_reg)] <= wdata_reg;
        if (cmd.fr_rd || cmd.rd_issue)
            fr_q <= frame_mem[fr_raddr];
    end

    // Owner store
    logic [10:0] owner_mem [OWNER_WORDS];

    always_ff @(posedge clk)
    begin
        if (cmd.own_wr)
            owner_mem[own_waddr] <= owner_reg;
        if (cmd.rd_issue)
        begin
            own_q   <= owner_mem[{rrow_reg[ROW_W-1:0], ocol[COL_W-1:0]}];
            oob_reg <= oob;
        end
    end

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_pixel_reg;
    logic [10:0] out_owner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pixel_reg <= oob_reg ? 32'd0 : fr_q;
            out_owner_reg <= oob_reg ? OWNER_NONE : own_q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_owner_reg, out_pixel_reg};

    // Status to controller
    assign stat.active    = active;
    assign stat.clipped   = clipped;
    assign stat.blend     = mode_reg;
    assign stat.alpha_nz  = argb_reg[31:ALPHA_LSB] != 8'd0;
    assign stat.last_copy = copy_reg == (sc_reg - 3'd1);
    assign stat.out_busy  = out_valid_reg && !m_tready;

endmodule

FILE: rtl/sprite_blitter_clip_alpha.sv
// Top level of the sprite blitter: controller plus datapath.
// Sprite blitter with clipping, horizontal replication and alpha blend. A header
// request (tuser 0) latches origin (position minus pan/scale), size, mode and
// owner. A pixel request (tuser 1) ends at evaluation when clipped or past the
// sprite's end; when opaque it writes the owner map and, with nonzero alpha, one
// frame word per replicated column; with alpha blend it reads, multiplies,
// finishes, then writes one word per replicated column through the single write
// port of the frame store. A read request (tuser 2) loads the result register once
// any previous result stalled on m_tready is taken. Stores are not cleared at reset.
module sprite_blitter_clip_alpha
    import sbca_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sprite_x, sprite_y, sprite_width, sprite_height, blend_alpha, owner_index,
    // pixel_argb, read_col, read_row
    input  logic [111:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_pixel, read_owner, zero pad
    output logic [47:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    sbca_cmd_t  cmd;
    sbca_stat_t stat;

    assign pready = 1'b1;

    sbca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    sbca_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/sbca_chk.sv
// Port-level checker of the sprite blitter and its bind.
module sbca_chk
    import sbca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // The block takes no request in the cycle after a read request
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == ACT_READ |=> !s_tready)
        else $error("request taken during read");

    // A fresh result is loaded while the block is busy with a read
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised outside a read");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind sprite_blitter_clip_alpha sbca_chk u_sbca_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
